// File: hw/rtl/bpb_pkg.sv
`default_nettype none

package bpb_pkg;

	localparam logic [1:0] OP_GRID_WR = 2'd0;
	localparam logic [1:0] OP_PAL_WR  = 2'd1;
	localparam logic [1:0] OP_RENDER  = 2'd2;

	localparam logic REG_PAL_OFFSET  = 1'b0;
	localparam logic REG_BLUR_WEIGHT = 1'b1;

	localparam logic [8:0] BLUR_RESET = 9'd96;
	localparam logic [8:0] WEIGHT_MAX = 9'd256;

	typedef struct packed {
		logic [1:0]  op;
		logic [10:0] grid_index;
		logic [7:0]  grid_value;
		logic [7:0]  palette_index;
		logic [15:0] palette_color;
		logic [8:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [15:0] prev_color;
		logic [3:0]  dither;
	} bpb_item_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] op;
	} bpb_ctl_t;

	typedef struct packed {
		logic [7:0]  palette_index;
		logic [15:0] palette_color;
		logic [15:0] prev_color;
		logic [3:0]  dither;
	} bpb_side_t;

	// a + floor((b - a) * w / 256), w in 0..256
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] w);
		logic [16:0] s;
		s = 17'(a) * 17'(WEIGHT_MAX - w) + 17'(b) * 17'(w);
		return s[15:8];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpb_coord.sv
`default_nettype none

module bpb_coord #(
	parameter int CELL_SIZE = 8,
	parameter int GRID_COLS = 41,
	parameter int GRID_ROWS = 31,
	parameter int AW        = 11
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_vld,
	input  bpb_pkg::bpb_item_t  item,
	output bpb_pkg::bpb_ctl_t   ctl_s4,
	output bpb_pkg::bpb_side_t  side_s4,
	output logic                gw_en_s4,
	output logic [AW-1:0]       gw_addr_s4,
	output logic [7:0]          gw_data_s4,
	output logic [AW-1:0]       a00_s4,
	output logic [AW-1:0]       a01_s4,
	output logic [AW-1:0]       a10_s4,
	output logic [AW-1:0]       a11_s4,
	output logic [7:0]          fx_s4,
	output logic [7:0]          fy_s4
);
	import bpb_pkg::*;

	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int RW = $clog2(CELL_SIZE);
	localparam logic [15:0] RECIP = 16'(65536 / CELL_SIZE);
	localparam int FRAC = 256 / CELL_SIZE;
	localparam logic [7:0] COL_LAST = 8'(GRID_COLS - 1);
	localparam logic [7:0] ROW_LAST = 8'(GRID_ROWS - 1);

	// stage 1: registered item
	bpb_ctl_t  ctl_s1;
	bpb_item_t item_s1;
	bpb_side_t side_s1;
	logic      gw_en_c1;
	logic [24:0] px_c1;
	logic [23:0] py_c1;

	// stage 2: approximate quotients
	bpb_ctl_t    ctl_s2;
	bpb_side_t   side_s2;
	logic        gw_en_s2;
	logic [AW-1:0] gw_addr_s2;
	logic [7:0]  gw_data_s2;
	logic [8:0]  x_s2;
	logic [7:0]  y_s2;
	logic [8:0]  qx_s2;
	logic [7:0]  qy_s2;
	logic [15:0] rx_c2, ry_c2;
	logic [9:0]  gx_raw_c2, gy_raw_c2;
	logic [RW-1:0] remx_c2, remy_c2;
	logic [7:0]  gx_c2, gy_c2;

	// stage 3: clamped cell and remainder
	bpb_ctl_t    ctl_s3;
	bpb_side_t   side_s3;
	logic        gw_en_s3;
	logic [AW-1:0] gw_addr_s3;
	logic [7:0]  gw_data_s3;
	logic [7:0]  gx_s3, gy_s3;
	logic [RW-1:0] remx_s3, remy_s3;
	logic [7:0]  gx1_c3, gy1_c3;
	logic [16:0] row0_c3, row1_c3;

	always_comb begin
		side_s1.palette_index = item_s1.palette_index;
		side_s1.palette_color = item_s1.palette_color;
		side_s1.prev_color    = item_s1.prev_color;
		side_s1.dither        = item_s1.dither;
		gw_en_c1 = ctl_s1.vld && (item_s1.op == OP_GRID_WR) &&
			(17'(item_s1.grid_index) < 17'(GRID_CELLS));
		px_c1 = 25'(item_s1.pixel_x) * 25'(RECIP);
		py_c1 = 24'(item_s1.pixel_y) * 24'(RECIP);
	end

	always_comb begin
		rx_c2 = 16'(x_s2) - 16'(qx_s2) * 16'(CELL_SIZE);
		ry_c2 = 16'(y_s2) - 16'(qy_s2) * 16'(CELL_SIZE);
		if (rx_c2 >= 16'(CELL_SIZE)) begin
			gx_raw_c2 = 10'(qx_s2) + 10'd1;
			remx_c2   = RW'(rx_c2 - 16'(CELL_SIZE));
		end else begin
			gx_raw_c2 = 10'(qx_s2);
			remx_c2   = RW'(rx_c2);
		end
		if (ry_c2 >= 16'(CELL_SIZE)) begin
			gy_raw_c2 = 10'(qy_s2) + 10'd1;
			remy_c2   = RW'(ry_c2 - 16'(CELL_SIZE));
		end else begin
			gy_raw_c2 = 10'(qy_s2);
			remy_c2   = RW'(ry_c2);
		end
		gx_c2 = (gx_raw_c2 > 10'(GRID_COLS - 1)) ? COL_LAST : gx_raw_c2[7:0];
		gy_c2 = (gy_raw_c2 > 10'(GRID_ROWS - 1)) ? ROW_LAST : gy_raw_c2[7:0];
	end

	always_comb begin
		gx1_c3  = (gx_s3 < COL_LAST) ? gx_s3 + 8'd1 : gx_s3;
		gy1_c3  = (gy_s3 < ROW_LAST) ? gy_s3 + 8'd1 : gy_s3;
		row0_c3 = 17'(gy_s3) * 17'(GRID_COLS);
		row1_c3 = 17'(gy1_c3) * 17'(GRID_COLS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			ctl_s4   <= '0;
			gw_en_s2 <= 1'b0;
			gw_en_s3 <= 1'b0;
			gw_en_s4 <= 1'b0;
		end else begin
			ctl_s1.vld <= in_vld;
			ctl_s1.op  <= item.op;
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			ctl_s4     <= ctl_s3;
			gw_en_s2   <= gw_en_c1;
			gw_en_s3   <= gw_en_s2;
			gw_en_s4   <= gw_en_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s1    <= item;

		side_s2    <= side_s1;
		gw_addr_s2 <= AW'(item_s1.grid_index);
		gw_data_s2 <= item_s1.grid_value;
		x_s2       <= item_s1.pixel_x;
		y_s2       <= item_s1.pixel_y;
		qx_s2      <= px_c1[24:16];
		qy_s2      <= py_c1[23:16];

		side_s3    <= side_s2;
		gw_addr_s3 <= gw_addr_s2;
		gw_data_s3 <= gw_data_s2;
		gx_s3      <= gx_c2;
		gy_s3      <= gy_c2;
		remx_s3    <= remx_c2;
		remy_s3    <= remy_c2;

		side_s4    <= side_s3;
		gw_addr_s4 <= gw_addr_s3;
		gw_data_s4 <= gw_data_s3;
		a00_s4     <= AW'(row0_c3 + 17'(gx_s3));
		a01_s4     <= AW'(row0_c3 + 17'(gx1_c3));
		a10_s4     <= AW'(row1_c3 + 17'(gx_s3));
		a11_s4     <= AW'(row1_c3 + 17'(gx1_c3));
		fx_s4      <= 8'(16'(remx_s3) * 16'(FRAC));
		fy_s4      <= 8'(16'(remy_s3) * 16'(FRAC));
	end

endmodule

`default_nettype wire

// File: hw/rtl/bpb_grid.sv
`default_nettype none

module bpb_grid #(
	parameter int GRID_CELLS = 1271,
	parameter int AW         = 11
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bpb_pkg::bpb_ctl_t   ctl_s4,
	input  bpb_pkg::bpb_side_t  side_s4,
	input  wire                 gw_en_s4,
	input  wire  [AW-1:0]       gw_addr_s4,
	input  wire  [7:0]          gw_data_s4,
	input  wire  [AW-1:0]       a00_s4,
	input  wire  [AW-1:0]       a01_s4,
	input  wire  [AW-1:0]       a10_s4,
	input  wire  [AW-1:0]       a11_s4,
	input  wire  [7:0]          fx_s4,
	input  wire  [7:0]          fy_s4,
	output bpb_pkg::bpb_ctl_t   ctl_s7,
	output bpb_pkg::bpb_side_t  side_s7,
	output logic [7:0]          val_s7
);
	import bpb_pkg::*;

	// two copies so each row pair gets its own two read ports
	logic [7:0] grid_top_mem [GRID_CELLS];
	logic [7:0] grid_bot_mem [GRID_CELLS];

	bpb_ctl_t  ctl_s5, ctl_s6;
	bpb_side_t side_s5, side_s6;
	logic [7:0] g00_s5, g01_s5, g10_s5, g11_s5;
	logic [7:0] fx_s5, fy_s5, fy_s6;
	logic [7:0] top_s6, bot_s6;

	always_ff @(posedge clk) begin
		if (gw_en_s4) begin
			grid_top_mem[gw_addr_s4] <= gw_data_s4;
			grid_bot_mem[gw_addr_s4] <= gw_data_s4;
		end
		g00_s5 <= grid_top_mem[a00_s4];
		g01_s5 <= grid_top_mem[a01_s4];
		g10_s5 <= grid_bot_mem[a10_s4];
		g11_s5 <= grid_bot_mem[a11_s4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		fx_s5   <= fx_s4;
		fy_s5   <= fy_s4;

		side_s6 <= side_s5;
		fy_s6   <= fy_s5;
		top_s6  <= lerp8(g00_s5, g01_s5, {1'b0, fx_s5});
		bot_s6  <= lerp8(g10_s5, g11_s5, {1'b0, fx_s5});

		side_s7 <= side_s6;
		val_s7  <= lerp8(top_s6, bot_s6, {1'b0, fy_s6});
	end

endmodule

`default_nettype wire

// File: hw/rtl/bpb_color.sv
`default_nettype none

module bpb_color (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [7:0]          palette_offset,
	input  wire  [8:0]          blur_weight,
	input  bpb_pkg::bpb_ctl_t   ctl_s7,
	input  bpb_pkg::bpb_side_t  side_s7,
	input  wire  [7:0]          val_s7,
	output logic                done,
	output logic [15:0]         pixel_color
);
	import bpb_pkg::*;

	function automatic logic [7:0] add_clamp(input logic [7:0] v, input logic [3:0] d);
		logic signed [9:0] s;
		s = signed'({2'b00, v}) + 10'($signed(d));
		if (s < 10'sd0) begin
			return 8'd0;
		end else if (s > 10'sd255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

	logic [15:0] pal_mem [256];

	logic [7:0]  pal_idx_c7;
	bpb_ctl_t    ctl_s8, ctl_s9;
	logic [15:0] color_s8, prev_s8;
	logic [3:0]  dither_s8, dither_s9;
	logic [8:0]  w_c8;
	logic [7:0]  cr_c8, cg_c8, cb_c8, pr_c8, pg_c8, pb_c8;
	logic [7:0]  r_s9, g_s9, b_s9;
	logic [7:0]  r_c9, g_c9, b_c9;
	logic        done_q;
	logic [15:0] pixel_color_q;

	assign pal_idx_c7 = val_s7 + palette_offset;

	always_ff @(posedge clk) begin
		if (ctl_s7.vld && (ctl_s7.op == OP_PAL_WR)) begin
			pal_mem[side_s7.palette_index] <= side_s7.palette_color;
		end
		color_s8 <= pal_mem[pal_idx_c7];
	end

	always_comb begin
		w_c8  = (blur_weight > WEIGHT_MAX) ? WEIGHT_MAX : blur_weight;
		cr_c8 = {color_s8[15:11], color_s8[15:13]};
		cg_c8 = {color_s8[10:5], color_s8[10:9]};
		cb_c8 = {color_s8[4:0], color_s8[4:2]};
		pr_c8 = {prev_s8[15:11], prev_s8[15:13]};
		pg_c8 = {prev_s8[10:5], prev_s8[10:9]};
		pb_c8 = {prev_s8[4:0], prev_s8[4:2]};
	end

	always_comb begin
		r_c9 = add_clamp(r_s9, dither_s9);
		g_c9 = add_clamp(g_s9, dither_s9);
		b_c9 = add_clamp(b_s9, dither_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8 <= '0;
			ctl_s9 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
			done_q <= ctl_s9.vld && (ctl_s9.op == OP_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		prev_s8       <= side_s7.prev_color;
		dither_s8     <= side_s7.dither;
		dither_s9     <= dither_s8;
		r_s9          <= lerp8(cr_c8, pr_c8, w_c8);
		g_s9          <= lerp8(cg_c8, pg_c8, w_c8);
		b_s9          <= lerp8(cb_c8, pb_c8, w_c8);
		pixel_color_q <= {r_c9[7:3], g_c9[7:2], b_c9[7:3]};
	end

	assign done        = done_q;
	assign pixel_color = pixel_color_q;

endmodule

`default_nettype wire

// File: hw/rtl/bilinear_palette_blur_pixel_top.sv
`default_nettype none

// Bilinear grid upscale, palette lookup and motion blur, one pixel per clock.
// The block takes a transaction at every rising edge where start is high;
// busy stays low, since the pipeline never stalls. Grid writes (op 0),
// palette writes (op 1) and render items (op 2) share one ordered pipeline,
// so a write is seen by every render item that follows it. A render item's
// pixel_color appears with done high for one cycle once the item has passed
// the nine register stages of the datapath and the output register. There is
// no backpressure: the receiver must take every result. Grid and palette
// contents are undefined after reset and have no clear pass, so load every
// entry a render item touches before rendering. Write cfg_* only while no
// transaction is in flight.
module bilinear_palette_blur_pixel_top #(
	parameter int CELL_SIZE = 8,
	parameter int GRID_COLS = 41,
	parameter int GRID_ROWS = 31
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         op,
	input  wire  [10:0]        grid_index,
	input  wire  [7:0]         grid_value,
	input  wire  [7:0]         palette_index,
	input  wire  [15:0]        palette_color,
	input  wire  [8:0]         pixel_x,
	input  wire  [7:0]         pixel_y,
	input  wire  [15:0]        prev_color,
	input  wire  signed [3:0]  dither,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [8:0]         cfg_data,
	output logic               done,
	output logic [15:0]        pixel_color
);
	import bpb_pkg::*;

	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int AW = $clog2(GRID_CELLS);

	logic [7:0] palette_offset_q;
	logic [8:0] blur_weight_q;

	bpb_item_t item;
	bpb_ctl_t  ctl_s4, ctl_s7;
	bpb_side_t side_s4, side_s7;
	logic          gw_en_s4;
	logic [AW-1:0] gw_addr_s4;
	logic [7:0]    gw_data_s4;
	logic [AW-1:0] a00_s4, a01_s4, a10_s4, a11_s4;
	logic [7:0]    fx_s4, fy_s4;
	logic [7:0]    val_s7;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_offset_q <= 8'd0;
			blur_weight_q    <= BLUR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAL_OFFSET: palette_offset_q <= cfg_data[7:0];
				REG_BLUR_WEIGHT: blur_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		item.op            = op;
		item.grid_index    = grid_index;
		item.grid_value    = grid_value;
		item.palette_index = palette_index;
		item.palette_color = palette_color;
		item.pixel_x       = pixel_x;
		item.pixel_y       = pixel_y;
		item.prev_color    = prev_color;
		item.dither        = dither;
	end

	bpb_coord #(
		.CELL_SIZE (CELL_SIZE),
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.AW        (AW)
	) u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (start && !busy),
		.item       (item),
		.ctl_s4     (ctl_s4),
		.side_s4    (side_s4),
		.gw_en_s4   (gw_en_s4),
		.gw_addr_s4 (gw_addr_s4),
		.gw_data_s4 (gw_data_s4),
		.a00_s4     (a00_s4),
		.a01_s4     (a01_s4),
		.a10_s4     (a10_s4),
		.a11_s4     (a11_s4),
		.fx_s4      (fx_s4),
		.fy_s4      (fy_s4)
	);

	bpb_grid #(
		.GRID_CELLS (GRID_CELLS),
		.AW         (AW)
	) u_grid (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s4     (ctl_s4),
		.side_s4    (side_s4),
		.gw_en_s4   (gw_en_s4),
		.gw_addr_s4 (gw_addr_s4),
		.gw_data_s4 (gw_data_s4),
		.a00_s4     (a00_s4),
		.a01_s4     (a01_s4),
		.a10_s4     (a10_s4),
		.a11_s4     (a11_s4),
		.fx_s4      (fx_s4),
		.fy_s4      (fy_s4),
		.ctl_s7     (ctl_s7),
		.side_s7    (side_s7),
		.val_s7     (val_s7)
	);

	bpb_color u_color (
		.clk            (clk),
		.arst_n         (arst_n),
		.palette_offset (palette_offset_q),
		.blur_weight    (blur_weight_q),
		.ctl_s7         (ctl_s7),
		.side_s7        (side_s7),
		.val_s7         (val_s7),
		.done           (done),
		.pixel_color    (pixel_color)
	);

`ifndef SYNTHESIS
	a_render_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_RENDER) |-> ##10 done)
		else $error("render transaction produced no result");

	a_write_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != OP_RENDER) |-> ##10 !done)
		else $error("result from a non-render transaction");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && op == OP_RENDER, 10))
		else $error("result without a render transaction");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bpb_pkg::*;

	localparam int CELL       = 8;
	localparam int COLS       = 41;
	localparam int ROWS       = 31;
	localparam int CELLS      = COLS * ROWS;
	localparam int LATENCY    = 12;
	localparam int STALL_MAX  = 5000;
	localparam int PER_PHASE  = 310;
	localparam int N_PHASES   = 6;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		bpb_item_t   it;
		logic        has_want;
		logic [15:0] want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	bpb_item_t   cur = '0;
	logic        cur_has_want = 1'b0;
	logic [15:0] cur_want = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data = '0;
	logic        busy;
	logic        done;
	logic [15:0] pixel_color;

	logic [7:0]  grid_mem [CELLS];
	bit          grid_set [CELLS];
	logic [15:0] pal_mem [256];
	bit          pal_set [256];
	logic [7:0]  offset_reg = 8'd0;
	logic [8:0]  weight_reg = BLUR_RESET;

	logic [15:0] colors_due [$];
	int          n_fail = 0;
	int          n_sent = 0;
	int          stall_cycles = 0;
	int          win_x = 0;
	int          win_y = 0;

	bilinear_palette_blur_pixel_top #(
		.CELL_SIZE(CELL),
		.GRID_COLS(COLS),
		.GRID_ROWS(ROWS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (cur.op),
		.grid_index   (cur.grid_index),
		.grid_value   (cur.grid_value),
		.palette_index(cur.palette_index),
		.palette_color(cur.palette_color),
		.pixel_x      (cur.pixel_x),
		.pixel_y      (cur.pixel_y),
		.prev_color   (cur.prev_color),
		.dither       (cur.dither),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.pixel_color  (pixel_color)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
			input int w);
		return 8'((int'(a) * (256 - w) + int'(b) * w) >> 8);
	endfunction

	function automatic void locate(input logic [8:0] x, input logic [7:0] y,
			output int i00, output int i01, output int i10, output int i11,
			output int fx, output int fy);
		int gx, gy, gx1, gy1;
		gx = int'(x) / CELL;
		gy = int'(y) / CELL;
		fx = (int'(x) % CELL) * (256 / CELL);
		fy = (int'(y) % CELL) * (256 / CELL);
		if (gx > COLS - 1) gx = COLS - 1;
		if (gy > ROWS - 1) gy = ROWS - 1;
		gx1 = (gx + 1 < COLS) ? gx + 1 : gx;
		gy1 = (gy + 1 < ROWS) ? gy + 1 : gy;
		i00 = gy * COLS + gx;
		i01 = gy * COLS + gx1;
		i10 = gy1 * COLS + gx;
		i11 = gy1 * COLS + gx1;
	endfunction

	function automatic logic [7:0] intensity_at(input logic [8:0] x, input logic [7:0] y);
		int i00, i01, i10, i11, fx, fy;
		logic [7:0] top, bot;
		locate(x, y, i00, i01, i10, i11, fx, fy);
		top = blend8(grid_mem[i00], grid_mem[i01], fx);
		bot = blend8(grid_mem[i10], grid_mem[i11], fx);
		return blend8(top, bot, fy);
	endfunction

	function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] p,
			input logic signed [3:0] d);
		int w, v;
		w = (weight_reg > WEIGHT_MAX) ? 256 : int'(weight_reg);
		v = int'(blend8(c, p, w)) + int'(d);
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	function automatic logic [15:0] shade_pixel(input bpb_item_t it);
		logic [15:0] c, p;
		logic [7:0]  r, g, b;
		c = pal_mem[8'(intensity_at(it.pixel_x, it.pixel_y) + offset_reg)];
		p = it.prev_color;
		r = mix_channel({c[15:11], c[15:13]}, {p[15:11], p[15:13]}, it.dither);
		g = mix_channel({c[10:5], c[10:9]}, {p[10:5], p[10:9]}, it.dither);
		b = mix_channel({c[4:0], c[4:2]}, {p[4:0], p[4:2]}, it.dither);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// accepted transactions, results and the no-progress watchdog
	always @(posedge clk) begin
		logic [15:0] due;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (start && !busy) begin
				case (cur.op)
					OP_GRID_WR: begin
						if (int'(cur.grid_index) < CELLS) begin
							grid_mem[cur.grid_index] = cur.grid_value;
							grid_set[cur.grid_index] = 1'b1;
						end
					end
					OP_PAL_WR: begin
						pal_mem[cur.palette_index] = cur.palette_color;
						pal_set[cur.palette_index] = 1'b1;
					end
					OP_RENDER: begin
						colors_due.push_back(cur_has_want ? cur_want : shade_pixel(cur));
					end
					default: begin
					end
				endcase
			end
			if (done) begin
				if (colors_due.size() == 0) begin
					$error("pixel_color: no result expected, got %h", pixel_color);
					n_fail = n_fail + 1;
				end else begin
					due = colors_due.pop_front();
					if (pixel_color !== due) begin
						$error("pixel_color mismatch: expected %h, got %h", due, pixel_color);
						n_fail = n_fail + 1;
					end
				end
			end
			if (stall_cycles >= STALL_MAX) begin
				$display("bilinear_palette_blur_pixel_top test failed");
				$finish;
			end
		end
	end

	function automatic int idle_pct();
		if (n_sent < 630) return 12;
		if (n_sent < 1260) return 58;
		return 0;
	endfunction

	task automatic maybe_idle();
		if ($urandom_range(0, 99) < idle_pct()) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	// called right after a falling edge; returns once the transaction is taken
	task automatic push_item(input bpb_item_t it, input logic has_want,
			input logic [15:0] want);
		cur          <= it;
		cur_has_want <= has_want;
		cur_want     <= want;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (colors_due.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_PAL_OFFSET)
			offset_reg = data[7:0];
		else
			weight_reg = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// builds one random transaction; renders that would read unloaded entries
	// turn into the write that loads them
	task automatic make_item(output bpb_item_t it, output bit counted);
		logic [95:0] r;
		int roll, i00, i01, i10, i11, fx, fy;
		logic [7:0] pidx;
		r = {$urandom(), $urandom(), $urandom()};
		it = r[81:0];
		counted = 1'b1;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			it.op = OP_NONE;
			counted = 1'b0;
		end else if (roll < 12) begin
			it.op = OP_GRID_WR;
			it.grid_index = 11'($urandom_range(CELLS, 2047));
			counted = 1'b0;
		end else if (roll < 27) begin
			it.op = OP_GRID_WR;
			it.grid_index = 11'($urandom_range(0, CELLS - 1));
		end else if (roll < 37) begin
			it.op = OP_PAL_WR;
		end else begin
			if ($urandom_range(0, 9) < 7) begin
				it.pixel_x = 9'(win_x + $urandom_range(0, 31));
				it.pixel_y = 8'(win_y + $urandom_range(0, 31));
			end
			locate(it.pixel_x, it.pixel_y, i00, i01, i10, i11, fx, fy);
			if (!grid_set[i00] || !grid_set[i01] || !grid_set[i10] || !grid_set[i11]) begin
				it.op = OP_GRID_WR;
				it.grid_index = 11'(!grid_set[i00] ? i00 : !grid_set[i01] ? i01 :
					!grid_set[i10] ? i10 : i11);
			end else begin
				pidx = intensity_at(it.pixel_x, it.pixel_y) + offset_reg;
				if (!pal_set[pidx]) begin
					it.op = OP_PAL_WR;
					it.palette_index = pidx;
				end else begin
					it.op = OP_RENDER;
				end
			end
		end
	endtask

	dir_row_t dir_rows [20];

	initial begin
		bpb_item_t it;
		bit counted;
		int phase_n;
		logic [8:0] offs [N_PHASES];
		logic [8:0] wts [N_PHASES];

		dir_rows = '{
			'{'{OP_NONE, 11'h7FF, 8'hFF, 8'hFF, 16'hFFFF, 9'h1FF, 8'hFF, 16'hFFFF, 4'hF},
				1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd2047, 8'hAA, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0},
				1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd1271, 8'h55, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0},
				1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd0, 8'd0, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0}, 1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd1, 8'd0, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0}, 1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd41, 8'd0, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0}, 1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd42, 8'd0, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0}, 1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd1270, 8'd255, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0},
				1'b0, 16'h0},
			'{'{OP_PAL_WR, 11'd0, 8'd0, 8'd0, 16'hFFFF, 9'h0, 8'h0, 16'h0, 4'h0}, 1'b0, 16'h0},
			'{'{OP_PAL_WR, 11'd0, 8'd0, 8'd255, 16'h0000, 9'h0, 8'h0, 16'h0, 4'h0},
				1'b0, 16'h0},
			// full white blended with white plus max dither clamps high
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd0, 8'd0, 16'hFFFF, 4'h7},
				1'b1, 16'hFFFF},
			// beyond the grid, black with black and min dither clamps low
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd511, 8'd255, 16'h0000, 4'h8},
				1'b1, 16'h0000},
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd7, 8'd7, 16'h1234, 4'h0}, 1'b0, 16'h0},
			// right and bottom edge
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd327, 8'd247, 16'hFFFF, 4'hF},
				1'b0, 16'h0},
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd3, 8'd5, 16'hF81F, 4'h3}, 1'b0, 16'h0},
			'{'{OP_GRID_WR, 11'd42, 8'd255, 8'h0, 16'h0, 9'h0, 8'h0, 16'h0, 4'h0},
				1'b0, 16'h0},
			'{'{OP_PAL_WR, 11'd0, 8'd0, 8'd195, 16'h07E0, 9'h0, 8'h0, 16'h0, 4'h0},
				1'b0, 16'h0},
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd7, 8'd7, 16'h0000, 4'h0}, 1'b0, 16'h0},
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd4, 8'd0, 16'h7BEF, 4'h5}, 1'b0, 16'h0},
			'{'{OP_RENDER, 11'd0, 8'd0, 8'd0, 16'h0, 9'd0, 8'd4, 16'h8410, 4'hC}, 1'b0, 16'h0}
		};

		offs = '{9'd0, 9'd255, 9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
			9'd128, 9'($urandom_range(0, 255))};
		wts = '{9'd0, 9'd256, 9'd511, 9'($urandom_range(0, 511)), 9'd255, 9'd1};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed, reset configuration
		foreach (dir_rows[i]) begin
			maybe_idle();
			@(negedge clk);
			push_item(dir_rows[i].it, dir_rows[i].has_want, dir_rows[i].want);
			n_sent = n_sent + 1;
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			write_reg(REG_PAL_OFFSET, offs[ph]);
			write_reg(REG_BLUR_WEIGHT, wts[ph]);
			phase_n = 0;
			while (phase_n < PER_PHASE) begin
				if (phase_n % 100 == 0) begin
					win_x = $urandom_range(0, 480);
					win_y = $urandom_range(0, 224);
				end
				maybe_idle();
				@(negedge clk);
				make_item(it, counted);
				push_item(it, 1'b0, 16'h0);
				if (counted) begin
					phase_n = phase_n + 1;
					n_sent = n_sent + 1;
				end
			end
		end

		wait_idle();
		if (n_fail == 0)
			$display("bilinear_palette_blur_pixel_top test passed");
		else
			$display("bilinear_palette_blur_pixel_top test failed");
		$finish;
	end

endmodule
